/* rtl/core/kdhc_pkg.sv */
`default_nettype none

package kdhc_pkg;

  localparam int TIME_BITS_DEFAULT = 32;

  localparam int NUM_BTN     = 3;
  localparam int BTN_UP_IX   = 0;
  localparam int BTN_DOWN_IX = 1;
  localparam int BTN_SEL_IX  = 2;

  localparam int NOW_BITS    = 32;
  localparam int PIN_BITS    = 3;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IX_BITS = 2;
  localparam int KEY_BITS    = 8;
  localparam int REVEAL_BITS = 2;

  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 16;

  localparam logic [CFG_IX_BITS-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IX_BITS-1:0] REG_HOLD     = 2'd1;
  localparam logic [CFG_IX_BITS-1:0] REG_CHORD    = 2'd2;

  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_BITS-1:0] HOLD_RESET     = 16'd600;
  localparam logic [CFG_BITS-1:0] CHORD_RESET    = 16'd2000;

  localparam logic [KEY_BITS-1:0] KEY_NONE = 8'd0;
  localparam logic [KEY_BITS-1:0] KEY_UP   = 8'd65;
  localparam logic [KEY_BITS-1:0] KEY_DOWN = 8'd66;
  localparam logic [KEY_BITS-1:0] KEY_SEL  = 8'd68;

  localparam logic [REVEAL_BITS-1:0] REVEAL_NONE = 2'd0;
  localparam logic [REVEAL_BITS-1:0] REVEAL_ON   = 2'd1;
  localparam logic [REVEAL_BITS-1:0] REVEAL_OFF  = 2'd2;

  function automatic logic [KEY_BITS-1:0] key_code(input int ix);
    case (ix)
      BTN_UP_IX:   key_code = KEY_UP;
      BTN_DOWN_IX: key_code = KEY_DOWN;
      BTN_SEL_IX:  key_code = KEY_SEL;
      default:     key_code = KEY_NONE;
    endcase
  endfunction

endpackage

`default_nettype wire

/* rtl/core/keypad_debounce_hold_chord_core.sv */
// A scan is registered in the input stage, then its result in the output stage.
// Throughput: one scan per cycle unless m_tready stalls; button state updates
// in the compute stage, so each scan sees the state left by the one before it.
// Reset (rst, synchronous, active high) clears all button and chord state,
// empties both stages and returns the thresholds to 50, 600 and 2000 ms.
`default_nettype none

module keypad_debounce_hold_chord_core
  import kdhc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Fields from bit 0: now_ms[31:0], pin_levels[34:32], zero fill [39:35].
  input  wire logic [IN_TDATA_BITS-1:0]  s_tdata,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: key_char[7:0], reveal_event[9:8], reboot_confirm[10],
  // zero fill [15:11].
  output logic [OUT_TDATA_BITS-1:0]      m_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IX_BITS-1:0]    cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data
);

  logic [CFG_BITS-1:0] debounce_time, hold_ms, chord_time;

  logic                 s1_valid;
  logic [NOW_BITS-1:0]  s1_now;
  logic [PIN_BITS-1:0]  s1_pins;

  logic [NUM_BTN-1:0]   raw_level, stable_level, hold_done;
  logic [TIME_BITS-1:0] change_stamp [NUM_BTN];
  logic [TIME_BITS-1:0] press_stamp  [NUM_BTN];
  logic [TIME_BITS-1:0] chord_start;
  logic                 chord_armed, chord_done;

  logic [NUM_BTN-1:0]   raw_level_next, stable_level_next, hold_done_next;
  logic [TIME_BITS-1:0] change_stamp_next [NUM_BTN];
  logic [TIME_BITS-1:0] press_stamp_next  [NUM_BTN];
  logic [TIME_BITS-1:0] chord_start_next;
  logic                 chord_armed_next, chord_done_next;

  logic [KEY_BITS-1:0]    key_char;
  logic [REVEAL_BITS-1:0] reveal_event;
  logic                   reboot_confirm;

  logic s2_adv, s_accept;

  assign cfg_ready = 1'b1;
  assign s2_adv    = !m_tvalid || m_tready;
  assign s_tready  = !s1_valid || s2_adv;
  assign s_accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time <= DEBOUNCE_RESET;
      hold_ms       <= HOLD_RESET;
      chord_time    <= CHORD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE: debounce_time <= cfg_data;
        REG_HOLD:     hold_ms       <= cfg_data;
        REG_CHORD:    chord_time    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [TIME_BITS-1:0] now;
    logic                 pressed;
    logic                 stop;
    now = TIME_BITS'(s1_now);
    stop = 1'b0;
    raw_level_next    = raw_level;
    stable_level_next = stable_level;
    hold_done_next    = hold_done;
    change_stamp_next = change_stamp;
    press_stamp_next  = press_stamp;
    chord_start_next  = chord_start;
    chord_armed_next  = chord_armed;
    chord_done_next   = chord_done;
    key_char       = KEY_NONE;
    reveal_event   = REVEAL_NONE;
    reboot_confirm = 1'b0;

    // A press edge ends the scan: later buttons and the chord are left as they are.
    for (int i = 0; i < NUM_BTN; i++) begin
      pressed = !s1_pins[i];
      if (!stop) begin
        if (pressed != raw_level[i]) begin
          raw_level_next[i]    = pressed;
          change_stamp_next[i] = now;
        end
        if ((now - change_stamp_next[i]) >= TIME_BITS'(debounce_time)) begin
          if (pressed != stable_level[i]) begin
            stable_level_next[i] = pressed;
            if (pressed) begin
              press_stamp_next[i] = now;
              hold_done_next[i]   = 1'b0;
              key_char            = key_code(i);
              stop                = 1'b1;
            end else begin
              if (hold_done[i]) begin
                reveal_event = REVEAL_OFF;
              end
              hold_done_next[i] = 1'b0;
            end
          end
          if (!stop && i == BTN_DOWN_IX && stable_level_next[i] && !hold_done_next[i] &&
              (now - press_stamp_next[i]) >= TIME_BITS'(hold_ms)) begin
            hold_done_next[i] = 1'b1;
            reveal_event      = REVEAL_ON;
          end
        end
      end
    end

    if (!stop) begin
      if (stable_level_next[BTN_DOWN_IX] && stable_level_next[BTN_SEL_IX]) begin
        if (!chord_armed) begin
          chord_start_next = now;
          chord_armed_next = 1'b1;
        end
        if (!chord_done && (now - chord_start_next) >= TIME_BITS'(chord_time)) begin
          chord_done_next = 1'b1;
          reboot_confirm  = 1'b1;
        end
      end else begin
        chord_armed_next = 1'b0;
        chord_start_next = '0;
        chord_done_next  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      raw_level    <= '0;
      stable_level <= '0;
      hold_done    <= '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        change_stamp[i] <= '0;
        press_stamp[i]  <= '0;
      end
      chord_start  <= '0;
      chord_armed  <= 1'b0;
      chord_done   <= 1'b0;
    end else begin
      if (s_accept) begin
        s1_valid <= 1'b1;
      end else if (s2_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s2_adv) begin
        m_tvalid     <= 1'b1;
        raw_level    <= raw_level_next;
        stable_level <= stable_level_next;
        hold_done    <= hold_done_next;
        change_stamp <= change_stamp_next;
        press_stamp  <= press_stamp_next;
        chord_start  <= chord_start_next;
        chord_armed  <= chord_armed_next;
        chord_done   <= chord_done_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_now  <= s_tdata[NOW_BITS-1:0];
      s1_pins <= s_tdata[NOW_BITS +: PIN_BITS];
    end
    if (s1_valid && s2_adv) begin
      m_tdata <= {5'd0, reboot_confirm, reveal_event, key_char};
    end
  end

`ifndef NO_ASSERTIONS
  // An empty output stage always frees the input stage.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input not ready while output stage is empty");

  // A press edge ends the scan before the chord check can report.
  a_key_no_reboot: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:0] != KEY_NONE) |-> !m_tdata[10])
    else $error("key press and reboot confirm in one result");

  // Only the down button ever records a fired hold.
  a_hold_only_down: assert property (@(posedge clk) disable iff (rst)
    !hold_done[BTN_UP_IX] && !hold_done[BTN_SEL_IX])
    else $error("hold recorded on a button other than down");

  // A reboot confirm is only reported while the chord is armed and marked done.
  a_reboot_marks_done: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_adv && reboot_confirm) |=> (chord_done && chord_armed))
    else $error("reboot confirm without chord state update");
`endif

endmodule

`default_nettype wire

/* test/keypad_debounce_hold_chord_core_test.sv */
`timescale 1ns / 1ps

module keypad_debounce_hold_chord_core_test;
  import kdhc_pkg::*;

  typedef struct packed {
    logic [KEY_BITS-1:0]    key_char;
    logic [REVEAL_BITS-1:0] reveal_event;
    logic                   reboot_confirm;
  } scan_event_t;

  class keypad_scoreboard;
    logic [CFG_BITS-1:0] debounce_time;
    logic [CFG_BITS-1:0] hold_ms;
    logic [CFG_BITS-1:0] chord_time;
    bit                  raw_pressed[NUM_BTN];
    bit                  stable_pressed[NUM_BTN];
    logic [NOW_BITS-1:0] change_time[NUM_BTN];
    logic [NOW_BITS-1:0] press_time[NUM_BTN];
    bit                  hold_fired[NUM_BTN];
    logic [NOW_BITS-1:0] chord_begin;
    bit                  chord_armed;
    bit                  chord_fired;
    logic [KEY_BITS-1:0] button_char[NUM_BTN];
    scan_event_t         expected_events[$];
    int                  errors;

    function new();
      button_char[BTN_UP_IX]   = KEY_UP;
      button_char[BTN_DOWN_IX] = KEY_DOWN;
      button_char[BTN_SEL_IX]  = KEY_SEL;
      errors = 0;
      debounce_time = DEBOUNCE_RESET;
      hold_ms       = HOLD_RESET;
      chord_time    = CHORD_RESET;
      for (int i = 0; i < NUM_BTN; i++) begin
        raw_pressed[i]    = 1'b0;
        stable_pressed[i] = 1'b0;
        change_time[i]    = '0;
        press_time[i]     = '0;
        hold_fired[i]     = 1'b0;
      end
      chord_begin = '0;
      chord_armed = 1'b0;
      chord_fired = 1'b0;
    endfunction

    function int pending();
      return expected_events.size();
    endfunction

    function void write_reg(logic [CFG_IX_BITS-1:0] index, logic [CFG_BITS-1:0] data);
      case (index)
        REG_DEBOUNCE: debounce_time = data;
        REG_HOLD:     hold_ms = data;
        REG_CHORD:    chord_time = data;
        default: ;
      endcase
    endfunction

    function void note_scan(logic [NOW_BITS-1:0] now, logic [PIN_BITS-1:0] pins);
      scan_event_t         ev;
      bit                  pressed;
      bit                  ended;
      logic [NOW_BITS-1:0] gap;
      ev = '0;
      ended = 1'b0;
      for (int i = 0; i < NUM_BTN; i++) begin
        pressed = !pins[i];
        if (pressed != raw_pressed[i]) begin
          raw_pressed[i] = pressed;
          change_time[i] = now;
        end
        gap = now - change_time[i];
        if (gap < debounce_time) continue;
        if (pressed != stable_pressed[i]) begin
          stable_pressed[i] = pressed;
          if (pressed) begin
            press_time[i] = now;
            hold_fired[i] = 1'b0;
            ev.key_char = button_char[i];
            ended = 1'b1;
            break;
          end
          if (hold_fired[i]) ev.reveal_event = REVEAL_OFF;
          hold_fired[i] = 1'b0;
        end
        gap = now - press_time[i];
        if (i == BTN_DOWN_IX && stable_pressed[i] && !hold_fired[i] && gap >= hold_ms) begin
          hold_fired[i] = 1'b1;
          ev.reveal_event = REVEAL_ON;
        end
      end
      // A press edge ends the scan before the chord is looked at.
      if (!ended) begin
        if (stable_pressed[BTN_DOWN_IX] && stable_pressed[BTN_SEL_IX]) begin
          if (!chord_armed) begin
            chord_begin = now;
            chord_armed = 1'b1;
          end
          gap = now - chord_begin;
          if (!chord_fired && gap >= chord_time) begin
            chord_fired = 1'b1;
            ev.reboot_confirm = 1'b1;
          end
        end else begin
          chord_armed = 1'b0;
          chord_begin = '0;
          chord_fired = 1'b0;
        end
      end
      expected_events.push_back(ev);
    endfunction

    function void check_result(logic [OUT_TDATA_BITS-1:0] tdata);
      scan_event_t want;
      if (expected_events.size() == 0) begin
        $error("result 0x%0h arrived with no scan outstanding", tdata);
        errors++;
        return;
      end
      want = expected_events.pop_front();
      if (tdata[7:0] !== want.key_char) begin
        $error("key_char: expected %0d, got %0d", want.key_char, tdata[7:0]);
        errors++;
      end
      if (tdata[9:8] !== want.reveal_event) begin
        $error("reveal_event: expected %0d, got %0d", want.reveal_event, tdata[9:8]);
        errors++;
      end
      if (tdata[10] !== want.reboot_confirm) begin
        $error("reboot_confirm: expected %0d, got %0d", want.reboot_confirm, tdata[10]);
        errors++;
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic [IN_TDATA_BITS-1:0]  s_tdata;
  logic                      s_tvalid;
  logic                      s_tready;
  logic [OUT_TDATA_BITS-1:0] m_tdata;
  logic                      m_tvalid;
  logic                      m_tready;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IX_BITS-1:0]    cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  keypad_scoreboard    sb = new();
  bit                  gaps_on = 1'b1;
  bit                  stall_request = 1'b0;
  logic [NOW_BITS-1:0] cur_now;
  logic [PIN_BITS-1:0] cur_pins;

  localparam int DIR_COUNT = 26;
  logic [NOW_BITS-1:0] dir_now [DIR_COUNT] = '{
    32'd0, 32'd20, 32'd70, 32'd90, 32'd140, 32'd150, 32'd200, 32'd800,
    32'd810, 32'd860, 32'd870, 32'd2869, 32'd2870, 32'd2900, 32'd2910, 32'd2960,
    32'd2970, 32'd3020, 32'd3030, 32'd3080, 32'd3630, 32'd3680, 32'd3700, 32'd3750,
    32'hFFFF_FFF0, 32'h0000_0030
  };
  logic [PIN_BITS-1:0] dir_pins [DIR_COUNT] = '{
    3'd7, 3'd6, 3'd6, 3'd7, 3'd7, 3'd5, 3'd5, 3'd5,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd5, 3'd5,
    3'd7, 3'd7, 3'd5, 3'd5, 3'd1, 3'd1, 3'd0, 3'd0,
    3'd7, 3'd7
  };

  keypad_debounce_hold_chord_core u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  initial begin
    #2_000_000;
    $display("keypad_debounce_hold_chord_core_test: done, errors");
    $finish;
  end

  // Receiver side: random back-pressure, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        m_tready <= 1'b0;
        repeat (300) @(negedge clk);
      end else begin
        m_tready <= gaps_on ? ($urandom_range(0, 99) >= 13) : 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  task automatic send_scan(input logic [NOW_BITS-1:0] now, input logic [PIN_BITS-1:0] pins);
    while (gaps_on && $urandom_range(0, 99) < 13) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_BITS'({pins, now});
    do @(posedge clk); while (!s_tready);
    sb.note_scan(now, pins);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IX_BITS-1:0] index, input logic [CFG_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(input logic [CFG_BITS-1:0] deb, input logic [CFG_BITS-1:0] hold,
                                input logic [CFG_BITS-1:0] chord);
    wait_drained();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_HOLD, hold);
    write_reg(REG_CHORD, chord);
  endtask

  // Mostly long held runs of a pin pattern, with glitches, pattern changes
  // and occasional jumps of the timestamp mixed in.
  task automatic random_scans(input int n, input int max_step, input int stall_at);
    logic [PIN_BITS-1:0] pins;
    int                  roll;
    for (int k = 0; k < n; k++) begin
      if (k == stall_at) stall_request = 1'b1;
      roll = $urandom_range(0, 99);
      cur_now = cur_now + NOW_BITS'($urandom_range(0, max_step));
      pins = cur_pins;
      if (roll < 6) begin
        pins = PIN_BITS'($urandom());
      end else if (roll < 8) begin
        cur_now = $urandom();
      end else if (roll < 14) begin
        case ($urandom_range(0, 5))
          0: cur_pins = 3'd7;
          1: cur_pins = 3'd6;
          2: cur_pins = 3'd5;
          3: cur_pins = 3'd3;
          4: cur_pins = 3'd1;
          default: cur_pins = PIN_BITS'($urandom());
        endcase
        pins = cur_pins;
      end
      send_scan(cur_now, pins);
    end
  endtask

  initial begin
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    cur_pins  = 3'd7;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pass on the reset thresholds.
    for (int k = 0; k < DIR_COUNT; k++) send_scan(dir_now[k], dir_pins[k]);

    // Short thresholds, starting just below the timestamp wrap.
    set_thresholds(16'd5, 16'd30, 16'd60);
    cur_now = 32'hFFFF_FF80;
    random_scans(110, 15, -1);

    // Zero thresholds with no idling on either side.
    set_thresholds(16'd0, 16'd0, 16'd0);
    gaps_on = 1'b0;
    random_scans(70, 3, -1);
    gaps_on = 1'b1;

    // Reset values again, with a long receiver hold-off.
    set_thresholds(DEBOUNCE_RESET, HOLD_RESET, CHORD_RESET);
    random_scans(110, 200, 30);

    // Largest thresholds with large time steps.
    set_thresholds(16'hFFFF, 16'hFFFF, 16'hFFFF);
    random_scans(80, 20000, -1);

    // An unused register index must change nothing, then random settings.
    wait_drained();
    write_reg(2'd3, 16'($urandom()));
    set_thresholds(16'($urandom_range(0, 40)), 16'($urandom_range(0, 200)),
                   16'($urandom_range(0, 400)));
    random_scans(120, 30, -1);

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.errors == 0) begin
      $display("keypad_debounce_hold_chord_core_test: done, clean");
    end else begin
      $display("keypad_debounce_hold_chord_core_test: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/kdhc_pkg.sv
rtl/core/keypad_debounce_hold_chord_core.sv
test/keypad_debounce_hold_chord_core_test.sv
